// ----- hdl/rrwc_pkg.sv -----
// rrwc_pkg: shared types and constants for the round-robin wait calculator
// holds field widths, datapath op codes and the controller/datapath command and status structs
// no dependencies
package rrwc_pkg;

   localparam int BURST_W    = 16;
   localparam int ARRIVAL_W  = 16;
   localparam int TIME_W     = 32;
   localparam int Q_W        = 8;
   localparam int OUT_IDX_W  = 6;
   localparam int REQ_DATA_W = BURST_W + ARRIVAL_W;
   localparam int RSP_FIELD_W = OUT_IDX_W + 2 * TIME_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELD_W;
   localparam int DIV_W      = BURST_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam logic [Q_W-1:0] QUANTUM_RESET = Q_W'(2);

   // what the datapath does with each table entry during a walk
   typedef enum logic [1:0] {
      OP_SCAN,
      OP_SWEEP,
      OP_RUN
   } op_type;

   typedef struct packed {
      logic   load;
      logic   time_clr;
      logic   count_clr;
      logic   walk_start;
      logic   walk;
      op_type op;
      logic   div_start;
      logic   mul1;
      logic   mul2;
      logic   skip_add;
      logic   tick;
      logic   out_start;
      logic   out_load;
      logic   out_next;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic skip_ok;
      logic div_done;
      logic quot_zero;
      logic ran;
      logic out_last;
   } sts_type;

endpackage

// ----- hdl/rrwc_div.sv -----
// rrwc_div: restoring divider, one quotient bit per cycle
// divides a 16-bit value by an 8-bit value; uses rrwc_pkg widths
module rrwc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_i,
   input  logic [rrwc_pkg::DIV_W-1:0]  dividend_i,
   input  logic [rrwc_pkg::Q_W-1:0]    divisor_i,
   output logic [rrwc_pkg::DIV_W-1:0]  quot_o,
   output logic                        done_o
);
   import rrwc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [Q_W:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [Q_W-1:0]       divisor_ff, divisor_in;
   logic [Q_W:0]         shifted;
   logic                 fits;

   assign shifted = {rem_ff[Q_W-1:0], quot_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start_i) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         cnt_in     = '0;
         rem_in     = '0;
         quot_in    = dividend_i;
         divisor_in = divisor_i;
      end else if (busy_ff) begin
         rem_in  = fits ? (shifted - {1'b0, divisor_ff}) : shifted;
         quot_in = {quot_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign quot_o = quot_ff;
   assign done_o = done_ff;

endmodule

// ----- hdl/rrwc_ctrl.sv -----
// rrwc_ctrl: sequencer for load, round-robin passes and result output
// drives rrwc_pkg::cmd_type to the datapath and reads rrwc_pkg::sts_type back
module rrwc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output rrwc_pkg::cmd_type cmd_o,
   input  rrwc_pkg::sts_type sts_i
);
   import rrwc_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SCAN_INIT,
      S_SCAN,
      S_DIV_START,
      S_DIV_WAIT,
      S_MUL1,
      S_MUL2,
      S_SKIP_ADD,
      S_SWEEP_INIT,
      S_SWEEP,
      S_RUN_INIT,
      S_RUN,
      S_PASS_END,
      S_OUT_RD,
      S_OUT_LOAD,
      S_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_xfer;

   assign rsp_xfer = rsp_valid_ff && rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_o        = '0;
      cmd_o.op     = OP_SCAN;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd_o.load = 1'b1;
               if (req_tlast) begin
                  cmd_o.time_clr = 1'b1;
                  state_in       = S_SCAN_INIT;
               end
            end
         end
         S_SCAN_INIT: begin
            cmd_o.walk_start = 1'b1;
            cmd_o.op         = OP_SCAN;
            state_in         = S_SCAN;
         end
         S_SCAN: begin
            cmd_o.walk = 1'b1;
            cmd_o.op   = OP_SCAN;
            if (sts_i.walk_done) begin
               state_in = sts_i.skip_ok ? S_DIV_START : S_RUN_INIT;
            end
         end
         S_DIV_START: begin
            cmd_o.div_start = 1'b1;
            state_in        = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts_i.div_done) begin
               state_in = sts_i.quot_zero ? S_RUN_INIT : S_MUL1;
            end
         end
         S_MUL1: begin
            cmd_o.mul1 = 1'b1;
            state_in   = S_MUL2;
         end
         S_MUL2: begin
            cmd_o.mul2 = 1'b1;
            state_in   = S_SKIP_ADD;
         end
         S_SKIP_ADD: begin
            cmd_o.skip_add = 1'b1;
            state_in       = S_SWEEP_INIT;
         end
         S_SWEEP_INIT: begin
            cmd_o.walk_start = 1'b1;
            cmd_o.op         = OP_SWEEP;
            state_in         = S_SWEEP;
         end
         S_SWEEP: begin
            cmd_o.walk = 1'b1;
            cmd_o.op   = OP_SWEEP;
            if (sts_i.walk_done) begin
               state_in = S_RUN_INIT;
            end
         end
         S_RUN_INIT: begin
            cmd_o.walk_start = 1'b1;
            cmd_o.op         = OP_RUN;
            state_in         = S_RUN;
         end
         S_RUN: begin
            cmd_o.walk = 1'b1;
            cmd_o.op   = OP_RUN;
            if (sts_i.walk_done) begin
               state_in = S_PASS_END;
            end
         end
         S_PASS_END: begin
            // an idle pass ends the schedule
            if (sts_i.ran) begin
               cmd_o.tick = 1'b1;
               state_in   = S_SCAN_INIT;
            end else begin
               cmd_o.out_start = 1'b1;
               state_in        = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            cmd_o.out_load = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (sts_i.out_last) begin
                  cmd_o.count_clr = 1'b1;
                  state_in        = S_LOAD;
               end else begin
                  cmd_o.out_next = 1'b1;
                  state_in       = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in     = S_LOAD;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT_LOAD))
      else $error("result raised without a table read");

endmodule

// ----- hdl/rrwc_dpath.sv -----
// rrwc_dpath: process table memories, schedule clock, pass accumulators and result register
// uses rrwc_pkg and the iterative divider rrwc_div
module rrwc_dpath #(
   parameter int MAX_PROCS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rrwc_pkg::Q_W-1:0]         csr_wdata,
   input  logic [rrwc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  rrwc_pkg::cmd_type                cmd_i,
   output rrwc_pkg::sts_type                sts_o,
   output logic [rrwc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import rrwc_pkg::*;

   localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int SPW = CW + Q_W;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PROCS);

   // table memories, one write and one registered read each
   logic [BURST_W-1:0]   burst_mem   [MAX_PROCS];
   logic [ARRIVAL_W-1:0] arrival_mem [MAX_PROCS];
   logic [BURST_W-1:0]   rem_mem     [MAX_PROCS];
   logic [TIME_W-1:0]    wait_mem    [MAX_PROCS];

   logic [BURST_W-1:0]   burst_rd_ff;
   logic [ARRIVAL_W-1:0] arr_rd_ff;
   logic [BURST_W-1:0]   rem_rd_ff;
   logic [TIME_W-1:0]    wait_rd_ff;

   logic [Q_W-1:0]     quantum_ff, quantum_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [TIME_W-1:0]  sim_time_ff, sim_time_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_idx_ff, pend_idx_in;
   logic               all_here_ff, all_here_in;
   logic [CW-1:0]      active_ff, active_in;
   logic [BURST_W-1:0] min_rem_ff, min_rem_in;
   logic               ran_ff, ran_in;
   logic [BURST_W-1:0] mq_ff, mq_in;
   logic [SPW-1:0]     span_ff, span_in;
   logic [TIME_W-1:0]  skip_ff, skip_in;

   logic [OUT_IDX_W-1:0] rsp_idx_ff;
   logic [TIME_W-1:0]    rsp_wait_ff;
   logic [TIME_W-1:0]    rsp_turn_ff;
   logic                 rsp_last_ff;

   logic [Q_W-1:0]       q_eff;
   logic [BURST_W-1:0]   ld_burst;
   logic [ARRIVAL_W-1:0] ld_arrival;
   logic                 load_ok;
   logic [IW-1:0]        ld_addr;
   logic [IW-1:0]        rd_addr;
   logic                 entry_live;
   logic                 entry_busy;
   logic                 arrived;
   logic                 scan_hit;
   logic                 run_hit;
   logic                 sweep_hit;
   logic                 run_more;
   logic [TIME_W-1:0]    finish_time;
   logic [BURST_W-1:0]   done_part;
   logic [TIME_W-1:0]    wait_val;
   logic                 rem_we;
   logic [IW-1:0]        rem_waddr;
   logic [BURST_W-1:0]   rem_wdata;
   logic                 wait_we;
   logic [IW-1:0]        wait_waddr;
   logic [TIME_W-1:0]    wait_wdata;
   logic [CW:0]          idx_plus;
   logic [DIV_W-1:0]     div_quot;
   logic                 div_done;
   logic [BURST_W+Q_W-1:0]   mq_full;
   logic [SPW-1:0]           span_full;
   logic [BURST_W+SPW-1:0]   skip_full;

   assign q_eff      = (quantum_ff == '0) ? Q_W'(1) : quantum_ff;
   assign ld_burst   = req_tdata[BURST_W-1:0];
   assign ld_arrival = req_tdata[REQ_DATA_W-1:BURST_W];
   assign load_ok    = cmd_i.load && (count_ff < COUNT_MAX);
   assign ld_addr    = count_ff[IW-1:0];
   assign rd_addr    = idx_ff[IW-1:0];

   assign entry_live = cmd_i.walk && pend_ff;
   assign entry_busy = rem_rd_ff != '0;
   assign arrived    = TIME_W'(arr_rd_ff) <= sim_time_ff;
   assign scan_hit   = entry_live && (cmd_i.op == OP_SCAN) && entry_busy;
   assign run_hit    = entry_live && (cmd_i.op == OP_RUN) && entry_busy && arrived;
   assign sweep_hit  = entry_live && (cmd_i.op == OP_SWEEP) && entry_busy;
   assign run_more   = rem_rd_ff > BURST_W'(q_eff);

   // finish time minus burst, using burst >= remaining
   assign finish_time = sim_time_ff + TIME_W'(rem_rd_ff);
   assign done_part   = burst_rd_ff - rem_rd_ff;
   assign wait_val    = sim_time_ff - TIME_W'(done_part);

   assign mq_full   = div_quot * q_eff;
   assign span_full = active_ff * q_eff + SPW'(1);
   assign skip_full = div_quot * span_ff;
   assign idx_plus  = {1'b0, idx_ff} + (CW + 1)'(1);

   rrwc_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (cmd_i.div_start),
      .dividend_i (min_rem_ff - BURST_W'(1)),
      .divisor_i  (q_eff),
      .quot_o     (div_quot),
      .done_o     (div_done)
   );

   // write port selection
   always_comb begin
      rem_we     = 1'b0;
      rem_waddr  = pend_idx_ff;
      rem_wdata  = '0;
      wait_we    = 1'b0;
      wait_waddr = pend_idx_ff;
      wait_wdata = '0;
      if (load_ok) begin
         rem_we     = 1'b1;
         rem_waddr  = ld_addr;
         rem_wdata  = ld_burst;
         wait_we    = 1'b1;
         wait_waddr = ld_addr;
      end else if (run_hit) begin
         rem_we    = 1'b1;
         rem_wdata = run_more ? (rem_rd_ff - BURST_W'(q_eff)) : '0;
         if (!run_more) begin
            wait_we    = 1'b1;
            wait_wdata = wait_val;
         end
      end else if (sweep_hit) begin
         rem_we    = 1'b1;
         rem_wdata = rem_rd_ff - mq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         burst_mem[ld_addr]   <= ld_burst;
         arrival_mem[ld_addr] <= ld_arrival;
      end
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      if (wait_we) begin
         wait_mem[wait_waddr] <= wait_wdata;
      end
      burst_rd_ff <= burst_mem[rd_addr];
      arr_rd_ff   <= arrival_mem[rd_addr];
      rem_rd_ff   <= rem_mem[rd_addr];
      wait_rd_ff  <= wait_mem[rd_addr];
   end

   always_comb begin
      quantum_in  = quantum_ff;
      count_in    = count_ff;
      sim_time_in = sim_time_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      all_here_in = all_here_ff;
      active_in   = active_ff;
      min_rem_in  = min_rem_ff;
      ran_in      = ran_ff;
      mq_in       = mq_ff;
      span_in     = span_ff;
      skip_in     = skip_ff;

      if (csr_we) begin
         quantum_in = csr_wdata;
      end

      if (cmd_i.count_clr) begin
         count_in = '0;
      end else if (load_ok) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd_i.time_clr) begin
         sim_time_in = '0;
      end else if (cmd_i.skip_add) begin
         sim_time_in = sim_time_ff + skip_ff;
      end else if (cmd_i.tick) begin
         sim_time_in = sim_time_ff + TIME_W'(1);
      end else if (run_hit) begin
         sim_time_in = run_more ? (sim_time_ff + TIME_W'(q_eff)) : finish_time;
      end

      // table walk: read address runs one entry ahead of the entry in use
      if (cmd_i.walk_start || cmd_i.out_start) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (cmd_i.walk) begin
         pend_in     = idx_ff < count_ff;
         pend_idx_in = idx_ff[IW-1:0];
         if (idx_ff < count_ff) begin
            idx_in = idx_plus[CW-1:0];
         end
      end else if (cmd_i.out_next) begin
         idx_in = idx_plus[CW-1:0];
      end

      if (cmd_i.walk_start && (cmd_i.op == OP_SCAN)) begin
         all_here_in = 1'b1;
         active_in   = '0;
         min_rem_in  = '1;
      end else if (scan_hit) begin
         if (!arrived) begin
            all_here_in = 1'b0;
         end else begin
            active_in = active_ff + CW'(1);
            if (rem_rd_ff < min_rem_ff) begin
               min_rem_in = rem_rd_ff;
            end
         end
      end

      if (cmd_i.walk_start && (cmd_i.op == OP_RUN)) begin
         ran_in = 1'b0;
      end else if (run_hit) begin
         ran_in = 1'b1;
      end

      if (cmd_i.mul1) begin
         mq_in   = mq_full[BURST_W-1:0];
         span_in = span_full;
      end
      if (cmd_i.mul2) begin
         skip_in = TIME_W'(skip_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff  <= QUANTUM_RESET;
         count_ff    <= '0;
         sim_time_ff <= '0;
         idx_ff      <= '0;
         pend_ff     <= 1'b0;
         ran_ff      <= 1'b0;
         all_here_ff <= 1'b0;
         active_ff   <= '0;
      end else begin
         quantum_ff  <= quantum_in;
         count_ff    <= count_in;
         sim_time_ff <= sim_time_in;
         idx_ff      <= idx_in;
         pend_ff     <= pend_in;
         ran_ff      <= ran_in;
         all_here_ff <= all_here_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      min_rem_ff  <= min_rem_in;
      mq_ff       <= mq_in;
      span_ff     <= span_in;
      skip_ff     <= skip_in;
      if (cmd_i.out_load) begin
         rsp_idx_ff  <= OUT_IDX_W'(idx_ff);
         rsp_wait_ff <= wait_rd_ff;
         rsp_turn_ff <= TIME_W'(burst_rd_ff) + wait_rd_ff;
         rsp_last_ff <= idx_plus == {1'b0, count_ff};
      end
   end

   assign rsp_tdata = {RSP_PAD_W'(0), rsp_turn_ff, rsp_wait_ff, rsp_idx_ff};
   assign rsp_tlast = rsp_last_ff;

   assign sts_o.walk_done = (idx_ff == count_ff) && !pend_ff;
   assign sts_o.skip_ok   = all_here_ff && (active_ff != '0);
   assign sts_o.div_done  = div_done;
   assign sts_o.quot_zero = div_quot == '0;
   assign sts_o.ran       = ran_ff;
   assign sts_o.out_last  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("process count beyond table depth");

   a_pend_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd_i.walk))
      else $error("table entry pending outside a walk");

   a_skip_min: assert property (@(posedge clock) disable iff (reset)
      sts_o.skip_ok |-> (min_rem_ff != '0))
      else $error("pass skip with an empty minimum");

endmodule

// ----- hdl/round_robin_wait_calculator_unit.sv -----
// round_robin_wait_calculator_unit: top level of the round-robin wait calculator
// joins rrwc_ctrl and rrwc_dpath; needs rrwc_pkg, rrwc_div
//
// Loads one process per cycle on the req stream (tdata: burst [15:0], arrival
// [31:16]; tlast marks the final process). Up to MAX_PROCS processes are kept; extra
// ones that are not last are dropped, and a last one past a full table is dropped but
// still starts the schedule. After the last process the unit replays round-robin
// scheduling from time zero with the quantum in csr_wdata (zero acts as one) and then
// returns one rsp transaction per process in load order. req_tready is low from the
// last process until the final result is taken. Each schedule pass walks the table
// memories at one entry per cycle, first in a scan and then in a run. When every
// remaining process has arrived, the passes in which all of them take a full slice are
// skipped in one step: a divide, multiplies, an add to the time and a sweep of the
// table. Results then leave one at a time, each read from the table and registered
// before it is offered, and stays offered until rsp_tready takes it.
module round_robin_wait_calculator_unit #(
   parameter int MAX_PROCS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // quantum register
   input  logic                             csr_we,
   input  logic [rrwc_pkg::Q_W-1:0]         csr_wdata,
   // tdata from bit 0: burst[15:0], arrival[15:0]; tlast: last_process
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rrwc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tlast,
   // tdata from bit 0: process_index[5:0], waiting_time[31:0], turnaround_time[31:0],
   // two zero bits; tlast: last_result
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rrwc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import rrwc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rrwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd_o      (cmd),
      .sts_i      (sts)
   );

   rrwc_dpath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd_i     (cmd),
      .sts_o     (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for round_robin_wait_calculator_unit
// streams process sets with random idling on both sides and checks every result against a
// built-in round-robin predictor or a typed row's values; needs rrwc_pkg and the unit's RTL
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rrwc_pkg::*;

   localparam int MAX_PROCS = 64;
   localparam int QUIET_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES = 64;
   localparam int PHASE_ITEMS = 14;

   typedef struct packed {
      logic [BURST_W-1:0]   burst;
      logic [ARRIVAL_W-1:0] arrival;
      logic                 last;
      logic                 typed;
      logic [TIME_W-1:0]    waiting;
      logic [TIME_W-1:0]    turnaround;
   } stim_row_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] proc_index;
      logic [TIME_W-1:0]    waiting;
      logic [TIME_W-1:0]    turnaround;
      logic                 last;
   } wait_result_type;

   typedef enum {SHAPE_SHORT, SHAPE_LONG, SHAPE_LATE} set_shape_type;

   // directed sets, quantum at its reset value of two
   localparam int DIRECTED_ROWS = 14;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{16'd0,     16'd0,     1'b1, 1'b1, 32'd0, 32'd0},      // zero burst
      '{16'd1,     16'd0,     1'b1, 1'b1, 32'd0, 32'd1},
      '{16'hFFFF,  16'd0,     1'b1, 1'b0, 32'd0, 32'd0},
      '{16'd1,     16'hFFFF,  1'b1, 1'b1, 32'd0, 32'd1},      // never arrives
      '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 32'd0, 32'd65535},
      '{16'd4,     16'd0,     1'b0, 1'b0, 32'd0, 32'd0},
      '{16'd0,     16'd0,     1'b0, 1'b0, 32'd0, 32'd0},
      '{16'd3,     16'd1,     1'b0, 1'b0, 32'd0, 32'd0},
      '{16'd6,     16'd2,     1'b1, 1'b0, 32'd0, 32'd0},
      '{16'd2,     16'd10,    1'b0, 1'b0, 32'd0, 32'd0},      // left unfinished
      '{16'd2,     16'd0,     1'b1, 1'b0, 32'd0, 32'd0},
      '{16'd1000,  16'd0,     1'b0, 1'b0, 32'd0, 32'd0},
      '{16'd999,   16'd0,     1'b0, 1'b0, 32'd0, 32'd0},
      '{16'd1,     16'd5,     1'b1, 1'b0, 32'd0, 32'd0}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [Q_W-1:0]        csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // predictor state
   logic [Q_W-1:0]       quantum_reg = QUANTUM_RESET;
   logic [BURST_W-1:0]   burst_tab [MAX_PROCS];
   logic [ARRIVAL_W-1:0] arrival_tab [MAX_PROCS];
   logic [BURST_W-1:0]   remaining_tab [MAX_PROCS];
   logic [TIME_W-1:0]    wait_tab [MAX_PROCS];
   int                   loaded_count = 0;

   wait_result_type waits_due [$];
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   int              sender_idle_pct = 21;
   int              receiver_idle_pct = 77;

   round_robin_wait_calculator_unit #(
      .MAX_PROCS (MAX_PROCS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // replays the schedule over the loaded table, filling wait_tab
   function automatic void replay_round_robin();
      logic [TIME_W-1:0] now, slice, active, min_rem, skip, r;
      bit all_here, ran;
      slice = (quantum_reg == '0) ? 32'd1 : 32'(quantum_reg);
      now = '0;
      do begin
         all_here = 1'b1;
         active = '0;
         min_rem = '1;
         ran = 1'b0;
         for (int i = 0; i < loaded_count; i++) begin
            if (remaining_tab[i] != '0) begin
               if (32'(arrival_tab[i]) > now) begin
                  all_here = 1'b0;
               end else begin
                  active++;
                  if (32'(remaining_tab[i]) < min_rem) min_rem = 32'(remaining_tab[i]);
               end
            end
         end
         // passes where everyone still running takes a full slice collapse into one step
         if (all_here && active != '0) begin
            skip = (min_rem - 1) / slice;
            if (skip != '0) begin
               now += skip * (active * slice + 1);
               for (int i = 0; i < loaded_count; i++) begin
                  if (remaining_tab[i] != '0)
                     remaining_tab[i] = 16'(32'(remaining_tab[i]) - skip * slice);
               end
            end
         end
         for (int i = 0; i < loaded_count; i++) begin
            r = 32'(remaining_tab[i]);
            if (r != '0 && 32'(arrival_tab[i]) <= now) begin
               ran = 1'b1;
               if (r > slice) begin
                  now += slice;
                  remaining_tab[i] = 16'(r - slice);
               end else begin
                  now += r;
                  wait_tab[i] = now - 32'(burst_tab[i]);
                  remaining_tab[i] = '0;
               end
            end
         end
         if (ran) now += 1;
      end while (ran);
   endfunction

   function automatic void load_and_schedule(input stim_row_type row,
                                             ref wait_result_type results [$]);
      results.delete();
      // a full table drops the process but a last marker still starts the schedule
      if (loaded_count < MAX_PROCS) begin
         burst_tab[loaded_count] = row.burst;
         arrival_tab[loaded_count] = row.arrival;
         remaining_tab[loaded_count] = row.burst;
         wait_tab[loaded_count] = '0;
         loaded_count++;
      end
      if (row.last) begin
         replay_round_robin();
         for (int i = 0; i < loaded_count; i++) begin
            results.push_back('{6'(i), wait_tab[i], 32'(burst_tab[i]) + wait_tab[i],
                                i == loaded_count - 1});
         end
         loaded_count = 0;
      end
   endfunction

   task automatic send_process(input stim_row_type row);
      wait_result_type results [$];
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= REQ_DATA_W'($urandom);
         req_tlast <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {row.arrival, row.burst};
      req_tlast <= row.last;
      do @(posedge clock); while (!req_tready);
      load_and_schedule(row, results);
      if (row.typed)
         waits_due.push_back('{6'd0, row.waiting, row.turnaround, 1'b1});
      else
         foreach (results[i]) waits_due.push_back(results[i]);
      @(negedge clock);
   endtask

   task automatic send_set(input int count, input set_shape_type shape);
      stim_row_type row;
      int late_pos;
      late_pos = $urandom_range(count - 1);
      for (int i = 0; i < count; i++) begin
         row = '0;
         row.last = (i == count - 1);
         case (shape)
            SHAPE_LONG: begin
               row.burst = 16'($urandom);
               row.arrival = 16'($urandom_range(7));
            end
            SHAPE_LATE: begin
               row.burst = 16'($urandom_range(63));
               row.arrival = (i == late_pos) ? 16'($urandom) : 16'($urandom_range(15));
            end
            default: begin
               row.burst = 16'($urandom_range(255));
               row.arrival = 16'($urandom_range(63));
            end
         endcase
         if ($urandom_range(7) == 0) row.burst = '0;
         send_process(row);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (waits_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_quantum(input logic [Q_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      quantum_reg = value;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      wait_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.proc_index = rsp_tdata[OUT_IDX_W-1:0];
         got.waiting = rsp_tdata[OUT_IDX_W +: TIME_W];
         got.turnaround = rsp_tdata[OUT_IDX_W + TIME_W +: TIME_W];
         got.last = rsp_tlast;
         if (waits_due.size() == 0) begin
            $display("%0t: unexpected result transaction, actual index %0d wait %0d",
                     $time, got.proc_index, got.waiting);
            mismatch_count++;
         end else begin
            want = waits_due.pop_front();
            if (got.proc_index !== want.proc_index)
               report_mismatch("process_index", 32'(want.proc_index), 32'(got.proc_index));
            if (got.waiting !== want.waiting)
               report_mismatch("waiting_time", want.waiting, got.waiting);
            if (got.turnaround !== want.turnaround)
               report_mismatch("turnaround_time", want.turnaround, got.turnaround);
            if (got.last !== want.last)
               report_mismatch("last_result", 32'(want.last), 32'(got.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [Q_W-1:0] phase_quantum [6];
      int items, count, pick;
      set_shape_type shape;
      phase_quantum[0] = 8'd1;
      phase_quantum[1] = 8'd255;
      phase_quantum[2] = 8'd0;
      phase_quantum[3] = 8'($urandom_range(3, 254));
      phase_quantum[4] = 8'd2;
      phase_quantum[5] = 8'($urandom_range(1, 16));

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_process(DIRECTED[i]);

      for (int ph = 0; ph < 6; ph++) begin
         drain_results();
         repeat (SETTLE_CYCLES) @(negedge clock);
         case (ph / 2)
            0: begin
               sender_idle_pct = 21;
               receiver_idle_pct = 77;
            end
            1: begin
               sender_idle_pct = 77;
               receiver_idle_pct = 21;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         write_quantum(phase_quantum[ph]);
         // one set that overflows the table: an ignored extra and a dropped last
         if (ph == 3) send_set(MAX_PROCS + 2, SHAPE_SHORT);
         items = 0;
         while (items < PHASE_ITEMS) begin
            if ($urandom_range(5) == 0) drain_results();
            count = $urandom_range(1, 8);
            pick = $urandom_range(99);
            shape = (pick < 65) ? SHAPE_SHORT : (pick < 85) ? SHAPE_LONG : SHAPE_LATE;
            send_set(count, shape);
            items += count;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
